@@ rtl/core/hydro_wave_speed_cfl_macros.svh @@
// Assertion helpers for the wave speed block.
`ifndef HYDRO_WAVE_SPEED_CFL_MACROS_SVH
`define HYDRO_WAVE_SPEED_CFL_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define HWS_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HWS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ rtl/core/hws_pkg.sv @@
// ----------------------------------------------------------------------------
// hws_pkg
// Types and constants shared by the wave speed and CFL block.
// ----------------------------------------------------------------------------
`default_nettype none
package hws_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int GAMMA_W = 19;
    localparam int CFG_W = 32;
    localparam logic [GAMMA_W-1:0] GAMMA_RST = 19'd109227;
    localparam logic [31:0] ICW_RST = 32'd65536;

    typedef enum logic {REG_GAMMA = 1'b0, REG_ICW = 1'b1} reg_idx_t;

    typedef struct packed {
        logic [31:0] density_left;
        logic signed [31:0] velocity_left;
        logic [31:0] pressure_left;
        logic [31:0] density_right;
        logic signed [31:0] velocity_right;
        logic [31:0] pressure_right;
        logic start_of_sweep;
    } in_item_t;

    typedef struct packed {
        logic [31:0] speed_plus;
        logic [31:0] speed_minus;
        logic [31:0] cfl_max;
        logic bad_density;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DIV, S_SCALE, S_SQRT, S_SIDE, S_COMB, S_PMUL, S_OUT
    } back_state_t;
endpackage
`default_nettype wire

@@ rtl/core/hws_front.sv @@
// ----------------------------------------------------------------------------
// hws_front
// Accepts transactions, classifies density, and queues them (two deep).
// ----------------------------------------------------------------------------
`default_nettype none
module hws_front (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  hws_pkg::in_item_t in_data,
    output logic q_valid,
    input  wire logic q_pop,
    output hws_pkg::in_item_t q_data,
    output logic q_bad
);
    import hws_pkg::*;
    in_item_t mem_reg [2];
    logic bad_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = mem_reg[rp_reg];
    assign q_bad = bad_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_data;
            bad_reg[wp_reg] <= (in_data.density_left == 32'd0) ||
                               (in_data.density_right == 32'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (q_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/hws_back.sv @@
// ----------------------------------------------------------------------------
// hws_back
// Sequencer with one shared radix-2 divider and square root, per item.
// ----------------------------------------------------------------------------
`default_nettype none
module hws_back #(
    parameter int FRAC_BITS = hws_pkg::FRAC_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    output logic q_pop,
    input  hws_pkg::in_item_t q_data,
    input  wire logic q_bad,
    input  wire logic [hws_pkg::GAMMA_W-1:0] gamma,
    input  wire logic [31:0] icw,
    output logic out_valid,
    input  wire logic out_stall,
    output hws_pkg::out_item_t out_data
);
    import hws_pkg::*;
    localparam int XW = 51;
    // The dividend keeps at least one bit above 64 so saturation is visible.
    localparam int DW = (XW + FRAC_BITS > 65) ? XW + FRAC_BITS : 65;
    localparam logic [63:0] MAX64 = '1;

    back_state_t st_reg, st_next;
    logic side_reg;
    logic [6:0] cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [32:0] rem_reg;
    logic [63:0] sq_reg, val_reg, res_reg, bit_reg;
    logic signed [34:0] a_reg, c_reg;
    logic [63:0] prod_reg;
    logic [31:0] sp_reg, sm_reg, run_reg;
    logic ov_valid_reg;
    out_item_t od_reg;

    logic [31:0] rho, p;
    logic signed [31:0] u;
    logic [33:0] trial;
    logic [63:0] rb;
    logic signed [34:0] cs, av, cv;
    logic [31:0] vmax, cfl, base;

    assign rho = side_reg ? q_data.density_right : q_data.density_left;
    assign p = side_reg ? q_data.pressure_right : q_data.pressure_left;
    assign u = side_reg ? q_data.velocity_right : q_data.velocity_left;
    assign trial = {rem_reg, quo_reg[DW-1]} - {2'b0, rho};
    assign rb = res_reg + bit_reg;
    assign cs = $signed({3'b0, res_reg[31:0]});
    assign av = cs + 35'(u);
    assign cv = cs - 35'(u);
    assign vmax = (sp_reg > sm_reg) ? sp_reg : sm_reg;
    assign cfl = (prod_reg[63:FRAC_BITS] > 64'hFFFFFFFF) ? 32'hFFFFFFFF
               : prod_reg[FRAC_BITS+31:FRAC_BITS];
    assign base = q_data.start_of_sweep ? 32'd0 : run_reg;
    assign out_valid = ov_valid_reg;
    assign out_data = od_reg;

    function automatic logic [31:0] clamp(input logic signed [34:0] v);
        if (v < 0) return 32'd0;
        if (v > 35'sh0FFFFFFFF) return 32'hFFFFFFFF;
        return v[31:0];
    endfunction

    always_comb
    begin
        st_next = st_reg;
        q_pop = 1'b0;
        case (st_reg)
            S_IDLE: if (q_valid) st_next = q_bad ? S_PMUL : S_MUL;
            S_MUL: st_next = S_DIV;
            S_DIV: if (cnt_reg == 7'(DW - 1)) st_next = S_SCALE;
            S_SCALE: st_next = S_SQRT;
            S_SQRT: if (bit_reg == 64'd0) st_next = S_SIDE;
            S_SIDE: st_next = side_reg ? S_COMB : S_MUL;
            S_COMB: st_next = S_PMUL;
            S_PMUL: st_next = S_OUT;
            S_OUT: if (!ov_valid_reg || !out_stall)
            begin
                st_next = S_IDLE;
                q_pop = 1'b1;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            run_reg <= 32'd0;
            ov_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (ov_valid_reg && !out_stall) ov_valid_reg <= 1'b0;
            if (q_pop)
            begin
                ov_valid_reg <= 1'b1;
                run_reg <= (cfl > base) ? cfl : base;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_IDLE:
            begin
                side_reg <= 1'b0;
                sp_reg <= 32'hFFFFFFFF;
                sm_reg <= 32'hFFFFFFFF;
            end
            S_MUL:
            begin
                quo_reg <= DW'({XW'(gamma) * XW'(p), {FRAC_BITS{1'b0}}});
                rem_reg <= 33'd0;
                cnt_reg <= 7'd0;
            end
            S_DIV:
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (!trial[33])
                begin
                    rem_reg <= trial[32:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[31:0], quo_reg[DW-1]};
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
            end
            S_SCALE:
            begin
                val_reg <= (quo_reg[DW-1:64] != '0) ? MAX64 : quo_reg[63:0];
                res_reg <= 64'd0;
                bit_reg <= 64'd1 << 62;
            end
            S_SQRT:
            begin
                if (bit_reg != 64'd0)
                begin
                    if (val_reg >= rb)
                    begin
                        val_reg <= val_reg - rb;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                        res_reg <= res_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                end
            end
            S_SIDE:
            begin
                side_reg <= 1'b1;
                if (!side_reg)
                begin
                    a_reg <= av;
                    c_reg <= cv;
                end
                else
                begin
                    sp_reg <= clamp((a_reg > av) ? a_reg : av);
                    sm_reg <= clamp((c_reg > cv) ? c_reg : cv);
                end
            end
            S_PMUL: prod_reg <= 64'(vmax) * 64'(icw);
            S_OUT: if (q_pop)
            begin
                od_reg.speed_plus <= sp_reg;
                od_reg.speed_minus <= sm_reg;
                od_reg.cfl_max <= (cfl > base) ? cfl : base;
                od_reg.bad_density <= q_bad;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/core/hydro_wave_speed_cfl.sv @@
// Wave speed and CFL estimator for one cell interface per transaction.
// Input channel: in_valid / in_stall with in_data (both sides rho, u, p and
// a start-of-sweep flag). Output channel: out_valid / out_stall with
// out_data (speeds, running CFL maximum, bad density flag).
// A two-entry queue decouples the front from the sequencer. The sequencer
// runs one radix-2 divider (gamma*p/rho, 67 steps) and one square root
// (32 steps) per side on shared logic and finishes each transaction before
// it takes the next; a zero density skips both sides.
// Registers are written through cfg_we / cfg_index / cfg_data; the user
// writes them only while idle, which the block itself does not enforce.
// Reset empties the queue, clears the running maximum and loads gamma 5/3
// and an inverse cell width of 1.0. A stalled result stays in the output
// register; the sequencer then holds its finished item and the queue fills.
// ----------------------------------------------------------------------------
// hydro_wave_speed_cfl
// Top level: configuration registers, front queue and back sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module hydro_wave_speed_cfl #(
    parameter int FRAC_BITS = hws_pkg::FRAC_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  hws_pkg::in_item_t in_data,
    output logic out_valid,
    input  wire logic out_stall,
    output hws_pkg::out_item_t out_data,
    input  wire logic cfg_we,
    input  wire logic cfg_index,
    input  wire logic [hws_pkg::CFG_W-1:0] cfg_data
);
    import hws_pkg::*;
    logic [GAMMA_W-1:0] gamma_reg;
    logic [31:0] icw_reg;
    logic q_valid, q_pop, q_bad;
    in_item_t q_data;

    // Register writes; index selects gamma or the inverse width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GAMMA_RST;
            icw_reg <= ICW_RST;
        end
        else if (cfg_we)
        begin
            if (reg_idx_t'(cfg_index) == REG_GAMMA) gamma_reg <= cfg_data[GAMMA_W-1:0];
            else icw_reg <= cfg_data;
        end
    end

    hws_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .in_data,
        .q_valid, .q_pop, .q_data, .q_bad
    );

    hws_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk, .rst_n, .q_valid, .q_pop, .q_data, .q_bad,
        .gamma(gamma_reg), .icw(icw_reg), .out_valid, .out_stall, .out_data
    );
endmodule
`default_nettype wire

@@ rtl/core/hws_checker.sv @@
// ----------------------------------------------------------------------------
// hws_checker
// Port-level checks on the wave speed block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hydro_wave_speed_cfl_macros.svh"
module hws_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input hws_pkg::out_item_t out_data
);
    // A bad density always reports saturated speeds.
    `HWS_ASSERT_IMP(a_bad_sat, clk, rst_n, out_valid && out_data.bad_density, out_data.speed_plus == 32'hFFFFFFFF && out_data.speed_minus == 32'hFFFFFFFF)
    // A stalled result stays presented.
    `HWS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    // Handshake outputs are always driven to known values outside reset.
    `HWS_ASSERT_IMP(a_known, clk, rst_n, 1'b1, !$isunknown(in_stall) && !$isunknown(out_valid))
endmodule
bind hydro_wave_speed_cfl hws_checker u_hws_checker (
    .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_data
);
`default_nettype wire

@@ tb/tb_hydro_wave_speed_cfl.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hydro_wave_speed_cfl
// Self-checking bench for the wave speed and CFL estimator.
// Sends interface states over the valid/stall channel with random gaps and
// back-pressure. A local bit-accurate predictor works out the expected
// speeds, running CFL maximum and bad density flag. A checker compares each
// result with the oldest expectation, field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_hydro_wave_speed_cfl;
    import hws_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;

    // Predictor copy of the configuration and the running maximum.
    logic [GAMMA_W-1:0] gamma_q;
    logic [31:0] inv_width_q;
    logic [31:0] sweep_cfl_max;

    out_item_t wave_results_due[$];
    int mismatches = 0;
    // Idle cycles before the next transaction; drawn when one is accepted.
    int in_gap = 0;

    hydro_wave_speed_cfl dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // Floor square root of a 64-bit value, digit by digit.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Sound speed of one side: sqrt(gamma * p / rho), rho nonzero.
    function automatic logic [63:0] side_sound_speed(input logic [31:0] rho,
                                                     input logic [31:0] p);
        logic [63:0] x;
        logic [63:0] q1;
        logic [63:0] r1;
        logic [63:0] sq;
        x = 64'(gamma_q) * 64'(p);
        q1 = x / 64'(rho);
        r1 = x % 64'(rho);
        if (q1 > (64'hFFFF_FFFF_FFFF_FFFF >> 16))
            sq = 64'hFFFF_FFFF_FFFF_FFFF;
        else
            sq = (q1 << 16) + ((r1 << 16) / 64'(rho));
        return floor_sqrt(sq);
    endfunction

    function automatic logic [31:0] clamp_speed(input logic signed [65:0] v);
        if (v < 0)
            return 32'd0;
        if (v > 66'sh0_FFFF_FFFF)
            return 32'hFFFF_FFFF;
        return v[31:0];
    endfunction

    // Expected result of one interface; also advances the running maximum.
    function automatic out_item_t predict_wave_speeds(input in_item_t it);
        out_item_t r;
        logic signed [65:0] cl, cr, a, b, c, d;
        logic [63:0] vmax;
        logic [95:0] prod;
        logic [31:0] cfl;
        r.bad_density = (it.density_left == 0) || (it.density_right == 0);
        if (r.bad_density)
        begin
            r.speed_plus = 32'hFFFF_FFFF;
            r.speed_minus = 32'hFFFF_FFFF;
        end
        else
        begin
            cl = $signed({2'b00, side_sound_speed(it.density_left, it.pressure_left)});
            cr = $signed({2'b00, side_sound_speed(it.density_right, it.pressure_right)});
            a = cl + 66'(it.velocity_left);
            b = cr + 66'(it.velocity_right);
            c = cl - 66'(it.velocity_left);
            d = cr - 66'(it.velocity_right);
            r.speed_plus = clamp_speed(a > b ? a : b);
            r.speed_minus = clamp_speed(c > d ? c : d);
        end
        vmax = (r.speed_plus > r.speed_minus) ? r.speed_plus : r.speed_minus;
        prod = (96'(vmax) * 96'(inv_width_q)) >> 16;
        cfl = (prod > 96'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
        if (it.start_of_sweep)
            sweep_cfl_max = 0;
        if (cfl > sweep_cfl_max)
            sweep_cfl_max = cfl;
        r.cfl_max = sweep_cfl_max;
        return r;
    endfunction

    // Sends one interface and queues its expected result at acceptance.
    // Valid drops at acceptance only when an idle gap follows, so a
    // back-to-back transaction never drives valid twice in one time step.
    task automatic send_interface(input in_item_t it);
        repeat (in_gap) @(posedge clk);
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        wave_results_due.push_back(predict_wave_speeds(it));
        in_gap = $urandom_range(0, 3);
        if (in_gap != 0)
            in_valid <= 1'b0;
    endtask

    // Waits for all results, then lets the sequencer settle.
    task automatic drain_results();
        if (in_gap == 0)
            in_valid <= 1'b0;
        while (wave_results_due.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_GAMMA)
            gamma_q = val[GAMMA_W-1:0];
        else
            inv_width_q = val;
    endtask

    // Physically plausible state: moderate density, pressure and velocity.
    function automatic in_item_t plausible_interface();
        in_item_t it;
        it.density_left = $urandom_range(32'h0000_1000, 32'h0040_0000);
        it.density_right = $urandom_range(32'h0000_1000, 32'h0040_0000);
        it.pressure_left = $urandom_range(0, 32'h0080_0000);
        it.pressure_right = $urandom_range(0, 32'h0080_0000);
        it.velocity_left = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        it.velocity_right = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        it.start_of_sweep = ($urandom_range(0, 15) == 0);
        return it;
    endfunction

    function automatic in_item_t wild_interface();
        in_item_t it;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom)};
        if ($urandom_range(0, 9) == 0)
            it.density_left = 0;
        if ($urandom_range(0, 9) == 0)
            it.density_right = 0;
        if ($urandom_range(0, 5) == 0)
            it.density_left = $urandom_range(1, 4);
        return it;
    endfunction

    // Directed corners: zero and full-scale fields, zero densities on each
    // side, huge sound speed, negative speeds clamped, and sweep restarts.
    task automatic test_directed_corners();
        in_item_t it;
        it = '{32'h0001_0000, 32'sh0, 32'h0001_0000, 32'h0001_0000, 32'sh0,
               32'h0001_0000, 1'b1};
        send_interface(it);
        it.density_left = 0;
        send_interface(it);
        it.density_left = 32'h0001_0000;
        it.density_right = 0;
        it.start_of_sweep = 1'b0;
        send_interface(it);
        it = '{32'd1, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'sh7FFF_FFFF,
               32'hFFFF_FFFF, 1'b0};
        send_interface(it);
        it = '{32'hFFFF_FFFF, 32'sh8000_0000, 32'd0, 32'hFFFF_FFFF,
               32'sh8000_0000, 32'd0, 1'b1};
        send_interface(it);
        it = '{32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'd0, 32'hFFFF_FFFF,
               32'sh8000_0000, 32'd0, 1'b0};
        send_interface(it);
        it = '{32'd1, 32'sh8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'sh0000_0001, 32'hFFFF_FFFF, 1'b0};
        send_interface(it);
        it = '{32'hFFFF_FFFF, 32'sh0, 32'hFFFF_FFFF, 32'd0, 32'sh8000_0000,
               32'hFFFF_FFFF, 1'b1};
        send_interface(it);
        repeat (6)
            send_interface(plausible_interface());
    endtask

    // Sweeps the registers through zero, their extremes and moderate values.
    task automatic test_register_settings();
        logic [31:0] gammas[4] = '{32'd65536, 32'd262144, 32'd0, 32'h7FFFF};
        logic [31:0] widths[4] = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd65536};
        for (int k = 0; k < 4; k++)
        begin
            drain_results();
            write_register(REG_GAMMA, gammas[k]);
            write_register(REG_ICW, widths[k]);
            repeat (15)
                send_interface(($urandom_range(0, 3) == 0) ? wild_interface()
                                                           : plausible_interface());
        end
        drain_results();
        write_register(REG_GAMMA, 32'd109227);
        write_register(REG_ICW, 32'd65536);
    endtask

    // Bulk random traffic; mostly plausible sweeps with some wild states.
    // Midway the sender holds off until the block has fully drained.
    task automatic test_random_sweeps();
        for (int n = 0; n < 1340; n++)
        begin
            if (n == 670)
                drain_results();
            if (n == 900)
            begin
                drain_results();
                write_register(REG_ICW, $urandom_range(1, 32'h0004_0000));
                write_register(REG_GAMMA, $urandom_range(65536, 262144));
            end
            send_interface(($urandom_range(0, 4) == 0) ? wild_interface()
                                                       : plausible_interface());
        end
    endtask

    // Receiver stall: random per result, with some long stall-free stretches.
    initial
    begin
        int hold;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 199) == 0)
                hold = -200;
            if (hold < 0)
            begin
                hold++;
                out_stall <= 1'b0;
            end
            else if (out_valid && !out_stall)
                out_stall <= ($urandom_range(0, 3) != 0) ? 1'b1 : 1'b0;
            else if (out_stall)
                out_stall <= ($urandom_range(0, 2) != 0) ? 1'b0 : 1'b1;
        end
    end

    // Result checker: every accepted transaction against the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (wave_results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", out_data);
            end
            else
            begin
                want = wave_results_due.pop_front();
                if (want.speed_plus !== out_data.speed_plus
                    || want.speed_minus !== out_data.speed_minus
                    || want.cfl_max !== out_data.cfl_max
                    || want.bad_density !== out_data.bad_density)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp sp=%h sm=%h cfl=%h bad=%b act sp=%h sm=%h cfl=%h bad=%b",
                                 want.speed_plus, want.speed_minus, want.cfl_max,
                                 want.bad_density, out_data.speed_plus,
                                 out_data.speed_minus, out_data.cfl_max,
                                 out_data.bad_density);
                end
            end
        end
    end

    initial
    begin
        gamma_q = GAMMA_RST;
        inv_width_q = ICW_RST;
        sweep_cfl_max = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_register_settings();
        test_random_sweeps();
        drain_results();
        if (mismatches == 0 && wave_results_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Worst case is about 1500 items through the sequencer plus stalls.
    initial
    begin
        #80ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
